### sv/hec_pkg.sv
package hec_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int DATA_W        = 57;
    localparam int CODE_W        = 63;
    localparam int SYN_W         = 6;
    localparam int CFG_W         = 6;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [CFG_W-1:0] DATA_BITS_RESET = 6'd4;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic {
        REG_DATA_BITS = 1'b0,
        REG_NONE      = 1'b1
    } t_reg_idx;

    // clamp the register value to the supported 1..MAX_DATA_BITS range
    function automatic logic [CFG_W-1:0] used_bits(logic [CFG_W-1:0] bits);
        logic [CFG_W-1:0] m;
        m = bits;
        if (m == '0) m = CFG_W'(1);
        if (m > CFG_W'(MAX_DATA_BITS)) m = CFG_W'(MAX_DATA_BITS);
        return m;
    endfunction

    // n = m + r, r the least value with 2^r >= m + r + 1
    function automatic logic [SYN_W-1:0] code_length(logic [CFG_W-1:0] bits);
        logic [CFG_W-1:0] m;
        logic [2:0]       r;
        m = used_bits(bits);
        r = '0;
        for (int i = 0; i < 7; i++) begin
            if ((7'd1 << r) < (7'(m) + 7'(r) + 7'd1)) r = r + 3'd1;
        end
        return SYN_W'(m) + SYN_W'(r);
    endfunction

    // codeword position (1-based) of data bit j: the j-th non-power-of-two index
    function automatic int data_position(int j);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int k = 1; k <= CODE_W; k++) begin
            if ((k & (k - 1)) != 0) begin
                if (cnt == j) pos = k;
                cnt++;
            end
        end
        return pos;
    endfunction

    // positions whose index has bit b set; bit k-1 stands for position k
    function automatic logic [CODE_W-1:0] cover_mask(int b);
        logic [CODE_W-1:0] msk;
        msk = '0;
        for (int k = 1; k <= CODE_W; k++) begin
            msk[k-1] = ((k >> b) & 1) != 0;
        end
        return msk;
    endfunction

endpackage

### sv/hamming_encode_correct_unit.sv
// Hamming single-error-correcting encoder / corrector.
//
// Input channel (i_valid / o_ready) carries one word: i_op selects encode of
// i_data_word or check-and-correct of i_code_word. Output channel
// (o_valid / i_ready) returns one word per input: o_code_out (bit k-1 is
// position k), o_error_position (syndrome, 0 on encode) and
// o_syndrome_out_of_range (syndrome beyond code length, no bit flipped).
//
// A word is held in the input register, then in the result register, where
// o_valid rises. Throughput: one word per cycle while the receiver keeps
// taking results; the XOR trees between the two registers are the whole
// datapath.
//
// The APB port holds data_bits at byte address 0; code length and masks are
// precomputed on write. Write only while no word is in flight.
//
// Reset (synchronous, active low) empties both stages and sets data_bits to 4
// (7-bit code). When the receiver stalls, the result register holds and the
// input register keeps its word; o_ready drops only once both are full.
module hamming_encode_correct_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input word
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [hec_pkg::DATA_W-1:0]     i_data_word,
    input  logic [hec_pkg::CODE_W-1:0]     i_code_word,
    // result word
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [hec_pkg::CODE_W-1:0]     o_code_out,
    output logic [hec_pkg::SYN_W-1:0]      o_error_position,
    output logic                           o_syndrome_out_of_range,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hec_pkg::PADDR_W-1:0]    paddr,
    input  logic [hec_pkg::PDATA_W-1:0]    pwdata,
    output logic [hec_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import hec_pkg::*;

    // configuration registers
    logic [CFG_W-1:0]  r_data_bits;
    logic [SYN_W-1:0]  r_code_len;
    logic [DATA_W-1:0] r_data_mask;
    logic [CODE_W-1:0] r_code_mask;

    // input stage
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [DATA_W-1:0] r_s1_data;
    logic [CODE_W-1:0] r_s1_code;

    // result stage
    logic              r_out_valid;
    t_op               r_out_op;
    logic [CODE_W-1:0] r_out_code;
    logic [SYN_W-1:0]  r_out_pos;
    logic              r_out_flag;

    logic              s1_advance;
    logic              in_accept;
    logic              cfg_write;
    t_reg_idx          cfg_idx;

    logic [CFG_W-1:0]  n_data_bits;
    logic [CFG_W-1:0]  cfg_m;

    logic [DATA_W-1:0] data_m;
    logic [CODE_W-1:0] scattered;
    logic [CODE_W-1:0] dec_word;
    logic [CODE_W-1:0] sel_word;
    logic [SYN_W-1:0]  syn;
    logic [CODE_W-1:0] enc_word;
    logic              syn_flag;
    logic [CODE_W-1:0] flip;
    logic [CODE_W-1:0] n_code;
    logic [SYN_W-1:0]  n_pos;
    logic              n_flag;

    // handshake: output stage frees when empty or taken
    assign s1_advance = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || s1_advance;
    assign in_accept  = i_valid && o_ready;

    // APB
    assign pready      = 1'b1;
    assign cfg_idx     = t_reg_idx'(paddr[2]);
    assign cfg_write   = psel && penable && pwrite && (cfg_idx == REG_DATA_BITS);
    assign n_data_bits = pwdata[CFG_W-1:0];
    assign cfg_m       = used_bits(n_data_bits);

    always_comb begin
        case (cfg_idx)
            REG_DATA_BITS: prdata = {{(PDATA_W-CFG_W){1'b0}}, r_data_bits};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_bits <= DATA_BITS_RESET;
            r_code_len  <= code_length(DATA_BITS_RESET);
            r_data_mask <= (DATA_W'(1) << used_bits(DATA_BITS_RESET)) - DATA_W'(1);
            r_code_mask <= (CODE_W'(1) << code_length(DATA_BITS_RESET)) - CODE_W'(1);
        end else if (cfg_write) begin
            r_data_bits <= n_data_bits;
            r_code_len  <= code_length(n_data_bits);
            r_data_mask <= (DATA_W'(1) << cfg_m) - DATA_W'(1);
            r_code_mask <= (CODE_W'(1) << code_length(n_data_bits)) - CODE_W'(1);
        end
    end

    // datapath between input and result register
    always_comb begin
        data_m    = r_s1_data & r_data_mask;
        scattered = '0;
        for (int j = 0; j < DATA_W; j++) begin
            scattered[data_position(j) - 1] = data_m[j];
        end
        dec_word = r_s1_code & r_code_mask;
        sel_word = (r_s1_op == OP_DECODE) ? dec_word : scattered;

        // syndrome: XOR of indices of set positions
        for (int b = 0; b < SYN_W; b++) begin
            syn[b] = ^(sel_word & cover_mask(b));
        end

        // encode: parity at 2^i lands the data syndrome, leaving zero overall
        enc_word = scattered;
        for (int i = 0; i < SYN_W; i++) begin
            enc_word[(1 << i) - 1] = syn[i];
        end

        syn_flag = syn > r_code_len;
        flip     = '0;
        if (syn != '0 && !syn_flag) flip = CODE_W'(1) << (syn - SYN_W'(1));

        if (r_s1_op == OP_DECODE) begin
            n_code = dec_word ^ flip;
            n_pos  = syn;
            n_flag = syn_flag;
        end else begin
            n_code = enc_word;
            n_pos  = '0;
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op   <= t_op'(i_op);
            r_s1_data <= i_data_word;
            r_s1_code <= i_code_word;
        end
        if (s1_advance && r_s1_valid) begin
            r_out_op   <= r_s1_op;
            r_out_code <= n_code;
            r_out_pos  <= n_pos;
            r_out_flag <= n_flag;
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_code_out              = r_out_code;
    assign o_error_position        = r_out_pos;
    assign o_syndrome_out_of_range = r_out_flag;

    // encode results never report a syndrome
    a_encode_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_op == OP_ENCODE) |->
            (r_out_pos == '0 && !r_out_flag))
        else $error("encode result carries syndrome");

    // out-of-range flag only for syndromes past the code length
    a_flag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flag) |-> (r_out_pos > r_code_len))
        else $error("out-of-range flag with in-range syndrome");

    // a word in the input stage moves on whenever the result stage frees
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_advance && !in_accept) |=> (!r_s1_valid && r_out_valid))
        else $error("input stage word not forwarded");

    // result bits above the code length stay clear
    a_code_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_code & ~r_code_mask) == '0))
        else $error("result bits beyond code length");

endmodule

### sim/hamming_encode_correct_unit_tb.sv
// Expected-result store for the Hamming unit: keeps its own copy of data_bits,
// predicts each accepted word and checks results in order.
class hamming_scoreboard;
    typedef struct {
        logic [hec_pkg::CODE_W-1:0] code;
        logic [hec_pkg::SYN_W-1:0]  pos;
        logic                       oor;
    } t_result;

    logic [hec_pkg::CFG_W-1:0] data_bits = hec_pkg::DATA_BITS_RESET;
    t_result expected_q[$];
    int errors;
    int n_encode;
    int n_decode;
    int n_fixed;
    int n_flagged;

    function int active_bits();
        int m = int'(data_bits);
        if (m < 1) m = 1;
        if (m > hec_pkg::MAX_DATA_BITS) m = hec_pkg::MAX_DATA_BITS;
        return m;
    endfunction

    function int code_len();
        int m = active_bits();
        int r = 0;
        while ((1 << r) < m + r + 1) r++;
        return m + r;
    endfunction

    function logic [hec_pkg::CODE_W-1:0] code_mask();
        logic [63:0] msk;
        msk = (64'd1 << code_len()) - 64'd1;
        return msk[hec_pkg::CODE_W-1:0];
    endfunction

    function int syndrome(logic [hec_pkg::CODE_W-1:0] w, int n);
        int s = 0;
        for (int k = 1; k <= n; k++) begin
            if (w[k-1]) s ^= k;
        end
        return s;
    endfunction

    function logic [hec_pkg::CODE_W-1:0] encode_data(logic [hec_pkg::DATA_W-1:0] d);
        logic [hec_pkg::CODE_W-1:0] w;
        int n;
        int j;
        int s;
        n = code_len();
        w = '0;
        j = 0;
        for (int k = 1; k <= n; k++) begin
            if ((k & (k - 1)) != 0) begin
                w[k-1] = d[j];
                j++;
            end
        end
        s = syndrome(w, n);
        for (int i = 0; (1 << i) <= n; i++) begin
            if (s[i]) w[(1 << i) - 1] = 1'b1;
        end
        return w;
    endfunction

    function void note_word(hec_pkg::t_op op, logic [hec_pkg::DATA_W-1:0] d,
                            logic [hec_pkg::CODE_W-1:0] c);
        t_result want;
        int n;
        int s;
        want.pos = '0;
        want.oor = 1'b0;
        if (op == hec_pkg::OP_ENCODE) begin
            want.code = encode_data(d);
            n_encode++;
        end else begin
            n = code_len();
            want.code = c & code_mask();
            s = syndrome(want.code, n);
            want.pos = s[hec_pkg::SYN_W-1:0];
            if (s > n) begin
                want.oor = 1'b1;
                n_flagged++;
            end else if (s != 0) begin
                want.code[s-1] = ~want.code[s-1];
                n_fixed++;
            end
            n_decode++;
        end
        expected_q.push_back(want);
    endfunction

    function void check_word(logic [hec_pkg::CODE_W-1:0] code,
                             logic [hec_pkg::SYN_W-1:0] pos, logic oor);
        t_result want;
        if (expected_q.size() == 0) begin
            $error("result word with nothing expected: code_out %h", code);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (code !== want.code) begin
            $error("code_out: expected %h, got %h", want.code, code);
            errors++;
        end
        if (pos !== want.pos) begin
            $error("error_position: expected %0d, got %0d", want.pos, pos);
            errors++;
        end
        if (oor !== want.oor) begin
            $error("syndrome_out_of_range: expected %0b, got %0b", want.oor, oor);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module hamming_encode_correct_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hec_pkg::*;

    // all block inputs start at known values
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                i_op        = 1'b0;
    logic [DATA_W-1:0]   i_data_word = '0;
    logic [CODE_W-1:0]   i_code_word = '0;
    logic                i_ready     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;

    logic                o_ready;
    logic                o_valid;
    logic [CODE_W-1:0]   o_code_out;
    logic [SYN_W-1:0]    o_error_position;
    logic                o_syndrome_out_of_range;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    hamming_scoreboard sb = new();

    // calm = no idling on either side (one long stretch of the run)
    logic calm = 1'b0;
    int   n_settings = 1;

    hamming_encode_correct_unit dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (i_valid),
        .o_ready                 (o_ready),
        .i_op                    (i_op),
        .i_data_word             (i_data_word),
        .i_code_word             (i_code_word),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_code_out              (o_code_out),
        .o_error_position        (o_error_position),
        .o_syndrome_out_of_range (o_syndrome_out_of_range),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stalls ~13% of cycles unless in the calm stretch
    always @(negedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end

    // result monitor: every accepted result word goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_word(o_code_out, o_error_position, o_syndrome_out_of_range);
        end
    end

    // Present one word. Entered at a rising edge, returns at the rising edge
    // where the word was taken. Valid stays high afterwards; the next call or
    // drain() decides at the next falling edge, so one assignment per step.
    task automatic send_word(input t_op op, input logic [DATA_W-1:0] d,
                             input logic [CODE_W-1:0] c);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_word <= d;
        i_code_word <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(op, d, c);
    endtask

    // hold the sender until every expected result is back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // one APB transfer: setup cycle, access cycle, done when pready is high
    task automatic apb_access(input logic wr, input t_reg_idx idx,
                              input logic [PDATA_W-1:0] wd,
                              output logic [PDATA_W-1:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // write data_bits (junk in the unused upper bits), then read it back
    task automatic set_data_bits(input logic [CFG_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, REG_DATA_BITS,
                   (PDATA_W'($urandom) & ~PDATA_W'(6'h3F)) | PDATA_W'(val), rd);
        sb.data_bits = val;
        n_settings++;
        apb_access(1'b0, REG_DATA_BITS, '0, rd);
        if (rd !== PDATA_W'(sb.data_bits)) begin
            $error("data_bits readback: expected %0d, got %0d", sb.data_bits, rd);
            sb.errors++;
        end
    endtask

    // Random word: mostly valid codewords with 0, 1 or 2 flipped positions
    // (2 flips reach syndromes past n when n is not 2^r-1), plus encodes and
    // raw noise. Bits above n get junk now and then; they must be dropped.
    task automatic random_word();
        logic [DATA_W-1:0] d;
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] junk;
        int n;
        int pick;
        int a;
        int b;
        n    = sb.code_len();
        d    = DATA_W'({$urandom, $urandom});
        junk = CODE_W'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_word(OP_ENCODE, d, junk);
        end else if (pick < 85) begin
            c = sb.encode_data(d);
            a = $urandom_range(1, n);
            b = $urandom_range(1, n - 1);
            if (b >= a) b++;
            pick = $urandom_range(0, 99);
            if (pick >= 15) c[a-1] = ~c[a-1];
            if (pick >= 75) c[b-1] = ~c[b-1];
            if ($urandom_range(0, 3) == 0) c = c | (junk & ~sb.code_mask());
            send_word(OP_DECODE, DATA_W'({$urandom, $urandom}), c);
        end else begin
            send_word(OP_DECODE, d, junk);
        end
    endtask

    initial begin
        logic [CODE_W-1:0]  w;
        logic [PDATA_W-1:0] rd;

        // synchronous reset, released at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: 4 data bits, 7-bit code
        send_word(OP_ENCODE, '0, '0);
        send_word(OP_ENCODE, '1, '1);          // data bits above m ignored
        send_word(OP_DECODE, '0, '0);
        send_word(OP_DECODE, '0, '1);          // bits above n ignored
        w = sb.encode_data(DATA_W'(4'hB));
        w[4] = ~w[4];                          // data position hit
        send_word(OP_DECODE, '1, w);
        w = sb.encode_data('0);
        w[3] = ~w[3];                          // parity position hit
        send_word(OP_DECODE, '0, w);
        repeat (20) random_word();

        // 2 data bits, n = 5: syndromes 6 and 7 fall past the code
        drain();
        set_data_bits(6'd2);
        send_word(OP_DECODE, '0, CODE_W'(5'b01010));
        send_word(OP_DECODE, '0, '1);
        repeat (20) random_word();

        // full width, n = 63
        drain();
        set_data_bits(6'(MAX_DATA_BITS));
        send_word(OP_ENCODE, '1, '0);
        send_word(OP_DECODE, '0, '1);
        w = sb.encode_data('1);
        w[CODE_W-1] = ~w[CODE_W-1];            // top position
        send_word(OP_DECODE, '0, w);
        w = sb.encode_data(DATA_W'({$urandom, $urandom}));
        w[0] = ~w[0];
        send_word(OP_DECODE, '1, w);
        send_word(OP_ENCODE, DATA_W'({(DATA_W+1)/2{2'b01}}), '0);
        repeat (20) random_word();

        // zero is taken as one data bit
        drain();
        set_data_bits('0);
        send_word(OP_ENCODE, '1, '0);
        send_word(OP_DECODE, '0, '1);
        repeat (20) random_word();

        // above the maximum clamps to full width
        drain();
        set_data_bits('1);
        send_word(OP_ENCODE, DATA_W'(1) << (DATA_W - 1), '0);
        send_word(OP_DECODE, '0, CODE_W'(1) << (CODE_W - 1));
        drain();
        // unmapped register: must leave data_bits alone
        apb_access(1'b1, REG_NONE, PDATA_W'(5), rd);
        apb_access(1'b0, REG_DATA_BITS, '0, rd);
        if (rd !== PDATA_W'(sb.data_bits)) begin
            $error("data_bits readback: expected %0d, got %0d", sb.data_bits, rd);
            sb.errors++;
        end
        repeat (20) random_word();

        // random settings; phase 3 runs with no idling on either side
        for (int p = 0; p < 12; p++) begin
            drain();
            set_data_bits((p == 0) ? 6'd1 : 6'($urandom_range(0, 63)));
            calm = (p == 3);
            for (int i = 0; i < 110; i++) begin
                if (p == 6 && i == 55) drain();
                random_word();
            end
        end
        calm = 1'b0;

        drain();
        repeat (4) @(posedge i_clk);
        $display("covered %0d encode and %0d decode words over %0d data_bits settings",
                 sb.n_encode, sb.n_decode, n_settings);
        $display("  %0d single-position corrections, %0d syndromes past the code length",
                 sb.n_fixed, sb.n_flagged);
        if (sb.errors == 0) begin
            $display("hamming_encode_correct_unit_tb: PASS");
        end else begin
            $display("hamming_encode_correct_unit_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("hamming_encode_correct_unit_tb: FAIL");
        $finish;
    end

endmodule
